// File: rtl/core/salwc_pkg.sv
// Shared types, codes and defaults for the set-associative LRU write-back cache.
`default_nettype none

package salwc_pkg;

    localparam int SETS_DEF      = 256;
    localparam int WAYS_DEF      = 4;
    localparam int ADDR_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [2:0] OFFSET_BITS_RST = 3'd5;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd8;
    localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic lookup_read;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/set_assoc_lru_writeback_cache_top.sv
// Top level of the set-associative LRU write-back, write-allocate tag cache.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------------
//   input    | in_valid / in_ready   | cmd, addr
//   result   | out_valid / out_ready | hit, way, writeback, writeback_addr, counters
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item goes through accept plus set row read, then hit/victim/LRU update and row write.
// The registered read of the set row RAM lies ahead of the row write.
// A full result register stalls the lookup until out_ready; the next item is
// still accepted while a result waits.
// After reset a clearing pass writes every set row (SETS rows, 256 by default),
// with in_ready low; config items are taken only in idle with no input item offered.
`default_nettype none

module set_assoc_lru_writeback_cache_top #(
    parameter int SETS      = salwc_pkg::SETS_DEF,
    parameter int WAYS      = salwc_pkg::WAYS_DEF,
    parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             cmd,
    input  wire logic [31:0]                      addr,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic [1:0]                            way,
    output logic                                  writeback,
    output logic [31:0]                           writeback_addr,
    output logic [31:0]                           read_total,
    output logic [31:0]                           read_misses,
    output logic [31:0]                           write_total,
    output logic [31:0]                           write_misses,
    output logic [31:0]                           writeback_total,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [salwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [salwc_pkg::CFG_DATA_W-1:0] cfg_data
);

    salwc_pkg::ctrl_cmd_t  ctl;
    salwc_pkg::dp_status_t sts;

    assign cfg_ready = in_ready && !in_valid;

    salwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    salwc_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .addr            (addr),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .way             (way),
        .writeback       (writeback),
        .writeback_addr  (writeback_addr),
        .read_total      (read_total),
        .read_misses     (read_misses),
        .write_total     (write_total),
        .write_misses    (write_misses),
        .writeback_total (writeback_total)
    );

endmodule

`default_nettype wire

// File: rtl/core/salwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module salwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/salwc_ctrl.sv
// Controller: clearing pass, item accept, lookup and commit sequencing.
`default_nettype none

module salwc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire salwc_pkg::dp_status_t  sts,
    output salwc_pkg::ctrl_cmd_t        ctl
);

    salwc_pkg::state_t state_reg;
    salwc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salwc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            salwc_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = salwc_pkg::ST_IDLE;
                end
            end
            salwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = salwc_pkg::ST_LOOKUP;
                end
            end
            salwc_pkg::ST_LOOKUP:
            begin
                if (sts.out_free)
                begin
                    state_next = salwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = salwc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        ctl.clear_step  = 1'b0;
        ctl.lookup_read = 1'b0;
        ctl.commit      = 1'b0;
        unique case (state_reg)
            salwc_pkg::ST_CLEAR:
            begin
                ctl.clear_step = 1'b1;
            end
            salwc_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                ctl.lookup_read = in_valid;
            end
            salwc_pkg::ST_LOOKUP:
            begin
                ctl.commit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == salwc_pkg::ST_LOOKUP)
        else $error("accepted item did not enter lookup");

    a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == salwc_pkg::ST_LOOKUP && !sts.out_free
        |=> state_reg == salwc_pkg::ST_LOOKUP && !in_ready)
        else $error("lookup left while result slot full");

    a_clear_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == salwc_pkg::ST_CLEAR && !sts.clear_last
        |=> state_reg == salwc_pkg::ST_CLEAR)
        else $error("clearing pass cut short");

    a_idle_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> in_ready && !ctl.commit && !ctl.clear_step)
        else $error("no return to idle after commit");

endmodule

`default_nettype wire

// File: rtl/core/salwc_dp.sv
// Datapath: config registers, set row RAM, hit/victim/LRU logic, counters, result register.
`default_nettype none

module salwc_dp #(
    parameter int SETS      = salwc_pkg::SETS_DEF,
    parameter int WAYS      = salwc_pkg::WAYS_DEF,
    parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire salwc_pkg::ctrl_cmd_t             ctl,
    output salwc_pkg::dp_status_t                 sts,
    input  wire logic                             cfg_valid,
    input  wire logic [salwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [salwc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             cmd,
    input  wire logic [31:0]                      addr,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  hit,
    output logic [1:0]                            way,
    output logic                                  writeback,
    output logic [31:0]                           writeback_addr,
    output logic [31:0]                           read_total,
    output logic [31:0]                           read_misses,
    output logic [31:0]                           write_total,
    output logic [31:0]                           write_misses,
    output logic [31:0]                           writeback_total
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_MAX = $clog2(SETS + 1) - 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int NW_W    = ($clog2(WAYS + 1) > 3) ? $clog2(WAYS + 1) : 3;
    localparam int ENTRY_W = ADDR_BITS + 2 + RANK_W;
    localparam int ROW_W   = WAYS * ENTRY_W;

    // configuration
    logic [2:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [2:0] ways_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= salwc_pkg::OFFSET_BITS_RST;
            index_bits_reg  <= salwc_pkg::INDEX_BITS_RST;
            ways_in_use_reg <= salwc_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                salwc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[2:0];
                salwc_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                salwc_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[2:0];
                default:                    offset_bits_reg <= offset_bits_reg;
            endcase
        end
    end

    logic [3:0]      ib_eff;
    logic [NW_W-1:0] nways;
    logic [4:0]      shift;

    always_comb
    begin
        ib_eff = index_bits_reg;
        if (index_bits_reg > 4'(IDX_MAX))
        begin
            ib_eff = 4'(IDX_MAX);
        end
        nways = NW_W'(ways_in_use_reg);
        if (ways_in_use_reg == 3'd0)
        begin
            nways = NW_W'(1);
        end
        else if (nways > NW_W'(WAYS))
        begin
            nways = NW_W'(WAYS);
        end
        shift = 5'(ib_eff) + 5'(offset_bits_reg);
    end

    // address split at accept
    logic [ADDR_BITS-1:0] addr_m;
    logic [ADDR_BITS-1:0] addr_sh;
    logic [SET_W-1:0]     set_in;
    logic [ADDR_BITS-1:0] tag_in;

    assign addr_m  = addr[ADDR_BITS-1:0];
    assign addr_sh = addr_m >> offset_bits_reg;
    assign set_in  = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << ib_eff);
    assign tag_in  = addr_m >> shift;

    logic                 cmd_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.lookup_read)
        begin
            cmd_reg <= cmd;
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
    end

    // clearing pass
    logic [SET_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    assign sts.clear_last = (clr_cnt_reg == SET_W'(SETS - 1));

    // set row memory
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_new;
    logic [ROW_W-1:0] row_rst;
    logic [ROW_W-1:0] row_wr;
    logic [SET_W-1:0] row_waddr;

    always_comb
    begin
        row_rst = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            row_rst[w*ENTRY_W +: RANK_W] = RANK_W'(w);
        end
    end

    assign row_wr    = ctl.clear_step ? row_rst : row_new;
    assign row_waddr = ctl.clear_step ? clr_cnt_reg : set_reg;

    salwc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ctl.clear_step | ctl.commit),
        .waddr (row_waddr),
        .wdata (row_wr),
        .re    (ctl.lookup_read),
        .raddr (set_in),
        .rdata (row_rd)
    );

    // lookup
    logic [ADDR_BITS-1:0] tag_a   [WAYS];
    logic                 valid_a [WAYS];
    logic                 dirty_a [WAYS];
    logic [RANK_W-1:0]    rank_a  [WAYS];
    logic                 hit_c;
    logic [WAY_W-1:0]     pos_c;
    logic [WAY_W-1:0]     vict_c;
    logic [WAY_W-1:0]     sel_c;
    logic [RANK_W-1:0]    sel_rank;
    logic                 wb_c;
    logic [ADDR_BITS-1:0] wb_addr_c;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            rank_a[w]  = row_rd[w*ENTRY_W +: RANK_W];
            dirty_a[w] = row_rd[w*ENTRY_W + RANK_W];
            valid_a[w] = row_rd[w*ENTRY_W + RANK_W + 1];
            tag_a[w]   = row_rd[w*ENTRY_W + RANK_W + 2 +: ADDR_BITS];
        end

        hit_c = 1'b0;
        pos_c = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (NW_W'(w) < nways && !hit_c && valid_a[w] && tag_a[w] == tag_reg)
            begin
                hit_c = 1'b1;
                pos_c = WAY_W'(w);
            end
        end

        vict_c = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (NW_W'(w) < nways && rank_a[w] > rank_a[vict_c])
            begin
                vict_c = WAY_W'(w);
            end
        end

        sel_c    = hit_c ? pos_c : vict_c;
        sel_rank = rank_a[sel_c];
        wb_c     = !hit_c && dirty_a[vict_c];
        wb_addr_c = wb_c ? ((tag_a[vict_c] << shift) |
                            (ADDR_BITS'(set_reg) << offset_bits_reg)) : '0;

        row_new = row_rd;
        for (int w = 0; w < WAYS; w++)
        begin
            if (NW_W'(w) < nways && rank_a[w] < sel_rank)
            begin
                row_new[w*ENTRY_W +: RANK_W] = rank_a[w] + RANK_W'(1);
            end
            if (WAY_W'(w) == sel_c)
            begin
                row_new[w*ENTRY_W +: RANK_W] = '0;
                if (hit_c)
                begin
                    if (cmd_reg == salwc_pkg::CMD_WRITE)
                    begin
                        row_new[w*ENTRY_W + RANK_W] = 1'b1;
                    end
                end
                else
                begin
                    row_new[w*ENTRY_W + RANK_W]                    = cmd_reg;
                    row_new[w*ENTRY_W + RANK_W + 1]                = 1'b1;
                    row_new[w*ENTRY_W + RANK_W + 2 +: ADDR_BITS]   = tag_reg;
                end
            end
        end
    end

    // result and counters
    logic        out_valid_reg;
    logic        hit_reg;
    logic [1:0]  way_reg;
    logic        wb_reg;
    logic [31:0] wb_addr_reg;
    logic [31:0] rd_cnt_reg;
    logic [31:0] rd_miss_cnt_reg;
    logic [31:0] wr_cnt_reg;
    logic [31:0] wr_miss_cnt_reg;
    logic [31:0] wb_cnt_reg;

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            rd_cnt_reg      <= '0;
            rd_miss_cnt_reg <= '0;
            wr_cnt_reg      <= '0;
            wr_miss_cnt_reg <= '0;
            wb_cnt_reg      <= '0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
            if (cmd_reg == salwc_pkg::CMD_WRITE)
            begin
                wr_cnt_reg <= wr_cnt_reg + 32'd1;
                if (!hit_c)
                begin
                    wr_miss_cnt_reg <= wr_miss_cnt_reg + 32'd1;
                end
            end
            else
            begin
                rd_cnt_reg <= rd_cnt_reg + 32'd1;
                if (!hit_c)
                begin
                    rd_miss_cnt_reg <= rd_miss_cnt_reg + 32'd1;
                end
            end
            if (wb_c)
            begin
                wb_cnt_reg <= wb_cnt_reg + 32'd1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            hit_reg     <= hit_c;
            way_reg     <= 2'(sel_c);
            wb_reg      <= wb_c;
            wb_addr_reg <= 32'(wb_addr_c);
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign way             = way_reg;
    assign writeback       = wb_reg;
    assign writeback_addr  = wb_addr_reg;
    assign read_total      = rd_cnt_reg;
    assign read_misses     = rd_miss_cnt_reg;
    assign write_total     = wr_cnt_reg;
    assign write_misses    = wr_miss_cnt_reg;
    assign writeback_total = wb_cnt_reg;

endmodule

`default_nettype wire
